@@ rtl/ftfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ftfp_pkg: shared types and constants for the fixed tick frame pacer
// Command and action codes plus the fixed register widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftfp_pkg;

   // register widths fixed by the register map
   localparam int PERIOD_W = 32;
   localparam int CATCH_W  = 16;
   localparam int LIMIT_W  = PERIOD_W + CATCH_W;

   localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd16667;
   localparam logic [CATCH_W-1:0]  CATCH_RST  = 16'd8;

   // CSR map, word index (paddr[2])
   localparam logic REG_TICK_PERIOD  = 1'b0;
   localparam logic REG_MAX_CATCH_UP = 1'b1;

   typedef enum logic [1:0] {
      CMD_ENABLE  = 2'd0,
      CMD_DISABLE = 2'd1,
      CMD_HOLD    = 2'd2,
      CMD_FRAME   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_DISABLED = 3'd0,
      ACT_HELD     = 3'd1,
      ACT_REBASED  = 3'd2,
      ACT_SKIP     = 3'd3,
      ACT_WAIT     = 3'd4,
      ACT_ON_TIME  = 3'd5
   } action_type;

endpackage

@@ rtl/fixed_tick_frame_pacer.sv @@
// ----------------------------------------------------------------------------
// fixed_tick_frame_pacer: fixed-rate tick scheduler for a frame loop
// Throughput: one transaction per cycle while the response is not stalled.
// An accepted req transaction enters the input register; a frame then loads
// its result into the result register, which drives rsp_tvalid; the frame
// decision is a single add / subtract / compare pass between the two.
// Reset: synchronous, active high; clears run/hold state, tick and event
// counters and origin; tick_period returns to 16667, max_catch_up to 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_tick_frame_pacer
   import ftfp_pkg::*;
#(
   parameter int TIME_BITS  = 48,
   parameter int COUNT_BITS = 32,
   localparam int REQ_RAW   = TIME_BITS + 1,
   localparam int REQ_W     = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW   = 4 * COUNT_BITS + TIME_BITS,
   localparam int RSP_W     = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,

   // request stream
   input  logic             req_tvalid,
   output logic             req_tready,
   // tdata, low bit up: now_time, hold_value, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // tuser: command
   input  logic [1:0]       req_tuser,

   // response stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tdata, low bit up: tick_number, wait_deadline, skip_count, wait_count,
   // rebase_count, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   // tuser: action
   output logic [2:0]       rsp_tuser,

   // CSR port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // compare width: big enough for both lag (TIME_BITS) and limit (48 bits)
   localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [PERIOD_W-1:0] tick_period_ff;
   logic [CATCH_W-1:0]  max_catch_up_ff;
   logic [LIMIT_W-1:0]  limit_ff;       // max_catch_up * tick_period
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff  <= PERIOD_RST;
         max_catch_up_ff <= CATCH_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TICK_PERIOD:  tick_period_ff  <= csr_pwdata;
            REG_MAX_CATCH_UP: max_catch_up_ff <= csr_pwdata[CATCH_W-1:0];
            default:          ;
         endcase
      end
   end

   // catch-up limit only moves with config, so the product is registered off
   // the datapath; user must write config only while block is idle, unchecked
   always_ff @(posedge clock) begin
      limit_ff <= LIMIT_W'(tick_period_ff) * LIMIT_W'(max_catch_up_ff);
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TICK_PERIOD:  csr_prdata = tick_period_ff;
         REG_MAX_CATCH_UP: csr_prdata = {{(32-CATCH_W){1'b0}}, max_catch_up_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   logic                 in_valid_ff;
   cmd_type              in_cmd_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 in_hold_ff;
   logic                 in_fire;      // stage leaves this cycle
   logic                 out_free;

   assign out_free   = !rsp_tvalid || rsp_tready;
   // frames need the result register, other commands retire silently
   assign in_fire    = in_valid_ff && (in_cmd_ff != CMD_FRAME || out_free);
   assign req_tready = !in_valid_ff || in_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_now_ff  <= req_tdata[TIME_BITS-1:0];
         in_hold_ff <= req_tdata[TIME_BITS];
      end
   end

   // ------------------------------------------------------------------
   // pacer state
   // ------------------------------------------------------------------
   logic                  running_ff,  running_in;
   logic                  holding_ff,  holding_in;
   logic [COUNT_BITS-1:0] tick_ff,     tick_in;
   logic [TIME_BITS-1:0]  origin_ff,   origin_in;
   logic [TIME_BITS-1:0]  due_ff,      due_in;     // tick_ff * period
   logic [COUNT_BITS-1:0] skipped_ff,  skipped_in;
   logic [COUNT_BITS-1:0] waited_ff,   waited_in;
   logic [COUNT_BITS-1:0] rebased_ff,  rebased_in;

   // frame datapath
   logic [TIME_BITS-1:0]  due_next;
   logic [TIME_BITS-1:0]  elapsed;
   logic [TIME_BITS-1:0]  lag;
   logic                  behind;
   logic                  over_limit;
   logic                  over_period;

   // result fields
   logic [COUNT_BITS-1:0] res_tick;
   action_type            res_action;
   logic [TIME_BITS-1:0]  res_deadline;

   assign due_next    = due_ff + TIME_BITS'(tick_period_ff);
   assign elapsed     = in_now_ff - origin_ff;
   assign lag         = elapsed - due_next;
   assign behind      = elapsed > due_next;
   assign over_limit  = CMP_W'(lag) > CMP_W'(limit_ff);
   assign over_period = lag > TIME_BITS'(tick_period_ff);

   always_comb begin
      running_in   = running_ff;
      holding_in   = holding_ff;
      tick_in      = tick_ff;
      origin_in    = origin_ff;
      due_in       = due_ff;
      skipped_in   = skipped_ff;
      waited_in    = waited_ff;
      rebased_in   = rebased_ff;
      res_tick     = '0;
      res_action   = ACT_DISABLED;
      res_deadline = '0;

      unique case (in_cmd_ff)
         CMD_ENABLE: begin
            running_in = 1'b1;
            holding_in = 1'b0;
            tick_in    = '0;
            due_in     = '0;
            skipped_in = '0;
            waited_in  = '0;
            origin_in  = in_now_ff;
         end
         CMD_DISABLE: begin
            if (running_ff) begin
               running_in = 1'b0;
               holding_in = 1'b0;
            end
         end
         CMD_HOLD: begin
            // release re-anchors the origin so counted ticks are due now
            if (in_hold_ff != holding_ff) begin
               holding_in = in_hold_ff;
               if (!in_hold_ff) begin
                  origin_in = in_now_ff - due_ff;
               end
            end
         end
         CMD_FRAME: begin
            priority if (!running_ff) begin
               res_action = ACT_DISABLED;
            end else if (holding_ff) begin
               res_tick   = tick_ff;
               res_action = ACT_HELD;
            end else begin
               res_tick = tick_ff;
               tick_in  = tick_ff + 1'b1;
               due_in   = due_next;
               priority if (behind && over_limit) begin
                  origin_in  = in_now_ff - due_next;
                  rebased_in = rebased_ff + 1'b1;
                  res_action = ACT_REBASED;
               end else if (behind && over_period) begin
                  skipped_in = skipped_ff + 1'b1;
                  res_action = ACT_SKIP;
               end else if (due_next > elapsed) begin
                  waited_in    = waited_ff + 1'b1;
                  res_action   = ACT_WAIT;
                  res_deadline = origin_ff + due_next;
               end else begin
                  res_action = ACT_ON_TIME;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         holding_ff <= 1'b0;
         tick_ff    <= '0;
         origin_ff  <= '0;
         due_ff     <= '0;
         skipped_ff <= '0;
         waited_ff  <= '0;
         rebased_ff <= '0;
      end else if (in_fire) begin
         running_ff <= running_in;
         holding_ff <= holding_in;
         tick_ff    <= tick_in;
         origin_ff  <= origin_in;
         due_ff     <= due_in;
         skipped_ff <= skipped_in;
         waited_ff  <= waited_in;
         rebased_ff <= rebased_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   action_type       rsp_action_ff;
   logic             rsp_load;

   assign rsp_load = in_fire && in_cmd_ff == CMD_FRAME;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // event counters shown are the post-update values
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff   <= RSP_W'({rebased_in, waited_in, skipped_in,
                                  res_deadline, res_tick});
         rsp_action_ff <= res_action;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_action_ff;

endmodule
